@@ hdl/rppu_pkg.sv @@
package rppu_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  // binary-angle accumulator, one guard bit over the folded 32-bit angle
  localparam int ANGLE_W = 33;
  localparam int ATAN_LEN = 32;

  // 1/K of an unlimited CORDIC, Q2.30
  localparam longint GAIN_Q30 = 64'sd652032874;

  // atan(2^-i), 2^32 per turn, rounded to nearest
  localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // request side data riding along the CORDIC row
  typedef struct packed {
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      flip;
  } carry_t;

endpackage

@@ hdl/rppu_cordic_cell.sv @@
module rppu_cordic_cell import rppu_pkg::*; #(
  parameter int STAGE = 0,
  parameter int CW    = 18
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [CW-1:0]       x_i,
  input  logic signed [CW-1:0]       y_i,
  input  logic signed [ANGLE_W-1:0]  z_i,
  input  carry_t                     carry_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [CW-1:0]       x_o,
  output logic signed [CW-1:0]       y_o,
  output logic signed [ANGLE_W-1:0]  z_o,
  output carry_t                     carry_o
);

  localparam logic signed [ANGLE_W-1:0] ATAN =
    signed'({{(ANGLE_W-32){1'b0}}, ATAN_TABLE[STAGE]});

  logic                      valid_r;
  logic signed [CW-1:0]      x_r, x_nxt;
  logic signed [CW-1:0]      y_r, y_nxt;
  logic signed [ANGLE_W-1:0] z_r, z_nxt;
  carry_t                    carry_r;
  logic signed [CW-1:0]      xs, ys;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!z_i[ANGLE_W-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      carry_r <= carry_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign carry_o = carry_r;

endmodule

@@ hdl/rppu_rotate.sv @@
module rppu_rotate import rppu_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int CW            = FRACTION_BITS_DEF + 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [CW-1:0]      cos_i,
  input  logic signed [CW-1:0]      sin_i,
  input  carry_t                    carry_i,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_rotated_x,
  output logic signed [COORD_W-1:0] out_rotated_y,
  output logic signed [COORD_W-1:0] out_rotated_z
);

  localparam int PW = DIFF_W + CW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRACTION_BITS - 1);

  // product stage
  logic                      m_valid_r;
  logic signed [PW-1:0]      dxc_r, dys_r, dyc_r, dxs_r;
  logic signed [COORD_W-1:0] m_px_r, m_py_r, m_pz_r;
  // sum stage
  logic                      s_valid_r;
  logic signed [SW-1:0]      sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [COORD_W-1:0] s_px_r, s_py_r, s_pz_r;
  // output stage
  logic                      o_valid_r;
  logic signed [COORD_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt, rz_r;

  logic                      rdy_m, rdy_s, rdy_o;
  logic signed [CW-1:0]      c, s;
  logic signed [SW-1:0]      tx, ty;

  assign rdy_o   = !o_valid_r || !out_stall;
  assign rdy_s   = !s_valid_r || rdy_o;
  assign rdy_m   = !m_valid_r || rdy_s;
  assign ready_o = rdy_m;

  // fold back the half turn taken off at the input
  assign c = carry_i.flip ? -cos_i : cos_i;
  assign s = carry_i.flip ? -sin_i : sin_i;

  always_comb begin
    sx_nxt = SW'(dxc_r) + SW'(dys_r) + HALF;
    sy_nxt = SW'(dyc_r) - SW'(dxs_r) + HALF;
  end

  always_comb begin
    tx = (sx_r >>> FRACTION_BITS) + SW'(s_px_r);
    ty = (sy_r >>> FRACTION_BITS) + SW'(s_py_r);
    if (tx[SW-1:COORD_W-1] == '0 || tx[SW-1:COORD_W-1] == '1) begin
      rx_nxt = tx[COORD_W-1:0];
    end else begin
      rx_nxt = tx[SW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    if (ty[SW-1:COORD_W-1] == '0 || ty[SW-1:COORD_W-1] == '1) begin
      ry_nxt = ty[COORD_W-1:0];
    end else begin
      ry_nxt = ty[SW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (rdy_m) m_valid_r <= valid_i;
      if (rdy_s) s_valid_r <= m_valid_r;
      if (rdy_o) o_valid_r <= s_valid_r;
    end
  end

  // full-width products: operands widen to PW in the assignment
  always_ff @(posedge clk) begin
    if (rdy_m && valid_i) begin
      dxc_r  <= carry_i.dx * c;
      dys_r  <= carry_i.dy * s;
      dyc_r  <= carry_i.dy * c;
      dxs_r  <= carry_i.dx * s;
      m_px_r <= carry_i.pivot_x;
      m_py_r <= carry_i.pivot_y;
      m_pz_r <= carry_i.point_z;
    end
    if (rdy_s && m_valid_r) begin
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      s_px_r <= m_px_r;
      s_py_r <= m_py_r;
      s_pz_r <= m_pz_r;
    end
    if (rdy_o && s_valid_r) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      rz_r <= s_pz_r;
    end
  end

  assign out_valid     = o_valid_r;
  assign out_rotated_x = rx_r;
  assign out_rotated_y = ry_r;
  assign out_rotated_z = rz_r;

endmodule

@@ hdl/rotate_point_about_pivot_unit.sv @@
// Rotates (point_x, point_y) clockwise by angle about (pivot_x, pivot_y) and passes
// point_z through; all coordinates signed Q16.16, angle 2^32 per turn, x and y
// saturate. One request is taken every cycle unless in_stall is high; a result passes
// through the input fold register, one CORDIC cell per stage, then the product, sum
// and round/saturate registers. Every register stage has its own valid bit, so empty
// slots close up while out_stall is high and requests keep being taken until the
// whole row is full.
module rotate_point_about_pivot_unit import rppu_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  logic signed [COORD_W-1:0] in_pivot_x,
  input  logic signed [COORD_W-1:0] in_pivot_y,
  input  logic signed [COORD_W-1:0] in_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_rotated_x,
  output logic signed [COORD_W-1:0] out_rotated_y,
  output logic signed [COORD_W-1:0] out_rotated_z
);

  localparam int N  = CORDIC_STAGES;
  localparam int CW = FRACTION_BITS + 2;
  localparam longint X0_L =
    (GAIN_Q30 + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
  localparam logic signed [CW-1:0] X0 = CW'(X0_L);

  logic                      valid_c [N+1];
  logic                      ready_c [N+1];
  logic signed [CW-1:0]      x_c     [N+1];
  logic signed [CW-1:0]      y_c     [N+1];
  logic signed [ANGLE_W-1:0] z_c     [N+1];
  carry_t                    carry_c [N+1];

  logic                      v0_r;
  logic signed [ANGLE_W-1:0] z0_r, z0_nxt;
  carry_t                    carry0_r, carry0_nxt;
  logic                      in_rdy;

  assign in_rdy   = !v0_r || ready_c[0];
  assign in_stall = !in_rdy;

  // second and third quadrant: add half a turn, negate cos/sin later
  always_comb begin
    carry0_nxt.flip    = in_angle[31] ^ in_angle[30];
    carry0_nxt.dx      = DIFF_W'(in_point_x) - DIFF_W'(in_pivot_x);
    carry0_nxt.dy      = DIFF_W'(in_point_y) - DIFF_W'(in_pivot_y);
    carry0_nxt.pivot_x = in_pivot_x;
    carry0_nxt.pivot_y = in_pivot_y;
    carry0_nxt.point_z = in_point_z;
    z0_nxt = ANGLE_W'(signed'({in_angle[31] ^ carry0_nxt.flip, in_angle[30:0]}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_rdy) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_valid) begin
      z0_r     <= z0_nxt;
      carry0_r <= carry0_nxt;
    end
  end

  assign valid_c[0] = v0_r;
  assign x_c[0]     = X0;
  assign y_c[0]     = '0;
  assign z_c[0]     = z0_r;
  assign carry_c[0] = carry0_r;

  for (genvar k = 0; k < N; k++) begin : g_cell
    rppu_cordic_cell #(
      .STAGE (k),
      .CW    (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .x_i     (x_c[k]),
      .y_i     (y_c[k]),
      .z_i     (z_c[k]),
      .carry_i (carry_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .x_o     (x_c[k+1]),
      .y_o     (y_c[k+1]),
      .z_o     (z_c[k+1]),
      .carry_o (carry_c[k+1])
    );
  end

  rppu_rotate #(
    .FRACTION_BITS (FRACTION_BITS),
    .CW            (CW)
  ) u_rotate (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (valid_c[N]),
    .ready_o       (ready_c[N]),
    .cos_i         (x_c[N]),
    .sin_i         (y_c[N]),
    .carry_i       (carry_c[N]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rotated_x (out_rotated_x),
    .out_rotated_y (out_rotated_y),
    .out_rotated_z (out_rotated_z)
  );

  // back-pressure only ever originates at the result side
  a_stall_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled without output back-pressure");

  // an empty fold register never refuses a request
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !v0_r |-> !in_stall)
    else $error("empty input stage stalled");

  // the last cell holds its item until the rotator takes it
  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_c[N] && !ready_c[N] |=> valid_c[N])
    else $error("item dropped at end of CORDIC row");

endmodule

@@ bench/tb_rotate_point_about_pivot_unit.sv @@
module tb_rotate_point_about_pivot_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rppu_pkg::*;

  localparam int STAGES      = CORDIC_STAGES_DEF;
  localparam int FRAC        = FRACTION_BITS_DEF;
  localparam int LATENCY     = STAGES + 4;
  localparam int N_RANDOM    = 550;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 300;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  // 1/K, Q2.30, and atan(2^-i) in binary-angle units
  localparam longint INV_GAIN_Q30 = 64'sd652032874;
  localparam longint ARCTAN [32] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331,  21354465,  10679838,  5340245,
    2670163,   1335087,   667544,    333772,
    166886,    83443,     41722,     20861,
    10430,     5215,      2608,      1304,
    652,       326,       163,       81,
    41,        20,        10,        5,
    3,         1,         1,         0
  };

  typedef struct {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [COORD_W-1:0] angle;
  } rot_req_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } rot_res_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic signed [COORD_W-1:0] in_pivot_x = '0;
  logic signed [COORD_W-1:0] in_pivot_y = '0;
  logic signed [COORD_W-1:0] in_angle = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_rotated_x;
  logic signed [COORD_W-1:0] out_rotated_y;
  logic signed [COORD_W-1:0] out_rotated_z;

  rot_req_t pending_reqs[$];
  rot_res_t rotations_due[$];

  int  total_reqs;
  int  accepted_reqs;
  int  results_checked;
  int  saturated_results;
  int  errors;
  int  idle_cycles;
  bit  req_fired;
  int  send_gap;
  int  send_calm;
  int  stall_left;
  int  recv_calm;
  int  hold_left;
  bit  hold_done;

  rotate_point_about_pivot_unit #(
    .CORDIC_STAGES(STAGES),
    .FRACTION_BITS(FRAC)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_point_z   (in_point_z),
    .in_pivot_x   (in_pivot_x),
    .in_pivot_y   (in_pivot_y),
    .in_angle     (in_angle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y),
    .out_rotated_z(out_rotated_z)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic rot_res_t predict_rotation(rot_req_t r);
    rot_res_t   res;
    logic [31:0] u;
    logic       flip;
    longint     x, y, z, xs, ys, dx, dy, half;
    u    = r.angle;
    flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
    // fold into [-1/4, 1/4) turn; cos and sin then change sign
    if (flip) u = u + 32'h8000_0000;
    z = longint'($signed(u));
    x = (INV_GAIN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    y = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    dx   = longint'(r.point_x) - longint'(r.pivot_x);
    dy   = longint'(r.point_y) - longint'(r.pivot_y);
    half = 64'sd1 <<< (FRAC - 1);
    res.x = 32'(clamp32(longint'(r.pivot_x) + ((dx * x + dy * y + half) >>> FRAC)));
    res.y = 32'(clamp32(longint'(r.pivot_y) + ((dy * x - dx * y + half) >>> FRAC)));
    res.z = r.point_z;
    return res;
  endfunction

  function automatic rot_req_t make_req(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz, logic signed [31:0] vx,
                                        logic signed [31:0] vy, logic signed [31:0] ang);
    rot_req_t r;
    r = '{px, py, pz, vx, vy, ang};
    return r;
  endfunction

  // mostly short, occasionally long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic signed [31:0] small_coord();
    return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
  endfunction

  function automatic logic signed [31:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] boundary_angle();
    logic [31:0] base;
    base = {2'($urandom_range(0, 3)), 30'd0};
    return base + $signed($urandom_range(0, 64)) - 32'sd32;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (%h) got %0d (%h)",
               $time, name, want, want, got, got);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    rot_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fired) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        in_point_x <= nxt.point_x;
        in_point_y <= nxt.point_y;
        in_point_z <= nxt.point_z;
        in_pivot_x <= nxt.pivot_x;
        in_pivot_y <= nxt.pivot_y;
        in_angle   <= nxt.angle;
        in_valid   <= 1'b1;
        // keep offering back to back while the receiver holds off
        if (accepted_reqs >= HOLD_AT && accepted_reqs < HOLD_AT + 40) begin
          send_gap = 0;
        end else if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) send_calm = 40;
          send_gap = pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && accepted_reqs >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (recv_calm > 0) begin
      recv_calm--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        recv_calm = 60;
        out_stall <= 1'b0;
      end else if (r < 30) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // acceptance, prediction and result checking
  always @(posedge clk) begin
    rot_res_t got, want;
    req_fired = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        req_fired = 1'b1;
        rotations_due.push_back(predict_rotation(make_req(in_point_x, in_point_y, in_point_z,
                                                          in_pivot_x, in_pivot_y, in_angle)));
        accepted_reqs++;
      end
      if (out_valid && !out_stall) begin
        got = '{out_rotated_x, out_rotated_y, out_rotated_z};
        if (rotations_due.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding, expected none got x=%0d y=%0d z=%0d",
                   $time, got.x, got.y, got.z);
        end else begin
          want = rotations_due.pop_front();
          check_field("rotated_x", want.x, got.x);
          check_field("rotated_y", want.y, got.y);
          check_field("rotated_z", want.z, got.z);
          if (want.x == C_MAX || want.x == C_MIN || want.y == C_MAX || want.y == C_MIN)
            saturated_results++;
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, rotations_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rot_req_t r;
    int       kind;

    // quadrant folding, boundary angles and unit vector
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(32'sh0001_0000, 0, 5, 0, 0, 32'sh4000_0000));
    pending_reqs.push_back(make_req(32'sh0001_0000, 0, 5, 0, 0, 32'sh3FFF_FFFF));
    pending_reqs.push_back(make_req(32'sh0001_0000, 0, 5, 0, 0, 32'sh8000_0000));
    pending_reqs.push_back(make_req(32'sh0001_0000, 0, 5, 0, 0, 32'sh7FFF_FFFF));
    pending_reqs.push_back(make_req(32'sh0001_0000, 0, 5, 0, 0, 32'shC000_0000));
    pending_reqs.push_back(make_req(32'sh0001_0000, 0, 5, 0, 0, 32'shBFFF_FFFF));
    pending_reqs.push_back(make_req(32'sh0001_0000, 0, 5, 0, 0, 32'shFFFF_FFFF));
    pending_reqs.push_back(make_req(32'sh0003_8000, -32'sh0002_4000, -7,
                                    32'sh0001_0000, 32'sh0001_0000, 32'sh2000_0000));
    pending_reqs.push_back(make_req(32'sh0001_0000, 32'sh0002_0000, 1,
                                    -32'sh0001_0000, 0, 32'sh6000_0000));
    pending_reqs.push_back(make_req(32'sh0001_0000, 32'sh0002_0000, 1,
                                    -32'sh0001_0000, 0, 32'shA000_0000));
    // widest offsets, with and without overflow
    pending_reqs.push_back(make_req(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 0));
    pending_reqs.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, 32'sh8000_0000));
    pending_reqs.push_back(make_req(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 32'sh8000_0000));
    pending_reqs.push_back(make_req(C_MAX, C_MIN, 0, C_MIN, C_MAX, 32'sh4000_0000));
    pending_reqs.push_back(make_req(C_MIN, C_MAX, -1, C_MAX, C_MIN, 32'shC000_0000));
    pending_reqs.push_back(make_req(C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, 32'sh1234_5678));
    pending_reqs.push_back(make_req(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    pending_reqs.push_back(make_req(-1, -1, -1, -1, -1, -1));
    pending_reqs.push_back(make_req(C_MAX, 0, C_MAX, 0, 0, 32'sh1000_0000));

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 8) begin
        r = make_req(small_coord(), small_coord(), $urandom, small_coord(), small_coord(),
                     $urandom);
      end else if (kind == 8) begin
        r = make_req(edge_coord(), edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     ($urandom_range(0, 1) != 0) ? boundary_angle() : edge_coord());
      end else begin
        r = make_req(small_coord(), small_coord(), $urandom, small_coord(), small_coord(),
                     boundary_angle());
        if ($urandom_range(0, 1) != 0) begin
          r.pivot_x = r.point_x;
          r.pivot_y = r.point_y;
        end
      end
      pending_reqs.push_back(r);
    end
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (accepted_reqs == total_reqs);
    wait (rotations_due.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (rotations_due.size() != 0) begin
      errors++;
      $display("%0t: %0d rotations never came out", $time, rotations_due.size());
    end

    $display("Rotated %0d points about their pivots across all four quadrants and the fold edges,",
             accepted_reqs);
    $display("%0d results checked (%0d clamped), %0d mismatches, with a long output hold-off",
             results_checked, saturated_results, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rppu_pkg.sv
hdl/rppu_cordic_cell.sv
hdl/rppu_rotate.sv
hdl/rotate_point_about_pivot_unit.sv
bench/tb_rotate_point_about_pivot_unit.sv
